@@ rtl/vpa_pkg.sv @@
// ============================================================================
// vpa_pkg
// Shared types, widths and the arctangent table of the polar angle pipeline.
// ============================================================================
package vpa_pkg;

  localparam int InputWidth  = 16;
  localparam int Iterations  = 16;
  localparam int TableLen    = 25;
  localparam int NumCells    = (Iterations > TableLen) ? TableLen : Iterations;
  localparam int FracBits    = 24;
  localparam int DataWidth   = InputWidth + FracBits + 4;
  localparam int AngleWidth  = 28;
  localparam int ShiftWidth  = 5;
  localparam int ExtraBits   = 11;
  localparam int ResWidth    = AngleWidth - ExtraBits;

  localparam logic signed [AngleWidth-1:0] HalfPiQ24  = 28'sd26353589;
  localparam logic signed [AngleWidth-1:0] RoundConst = 28'sd1024;
  localparam logic signed [ResWidth-1:0]   PiQ13      = 17'sd25736;
  localparam logic signed [ResWidth-1:0]   NegPiQ13   = -17'sd25736;

  typedef struct packed {
    logic signed [InputWidth-1:0] x_coord;
    logic signed [InputWidth-1:0] y_coord;
  } vpa_in_t;

  typedef struct packed {
    logic signed [15:0] angle;
    logic               at_origin;
  } vpa_out_t;

  typedef struct packed {
    logic                         origin;
    logic signed [DataWidth-1:0]  x;
    logic signed [DataWidth-1:0]  y;
    logic signed [AngleWidth-1:0] z;
  } vpa_stage_t;

  function automatic logic signed [AngleWidth-1:0] atan_q24(input logic [ShiftWidth-1:0] idx);
    logic signed [AngleWidth-1:0] val;
    unique case (idx)
      5'd0:    val = 28'sd13176795;
      5'd1:    val = 28'sd7778716;
      5'd2:    val = 28'sd4110060;
      5'd3:    val = 28'sd2086331;
      5'd4:    val = 28'sd1047214;
      5'd5:    val = 28'sd524117;
      5'd6:    val = 28'sd262123;
      5'd7:    val = 28'sd131069;
      5'd8:    val = 28'sd65536;
      5'd9:    val = 28'sd32768;
      5'd10:   val = 28'sd16384;
      5'd11:   val = 28'sd8192;
      5'd12:   val = 28'sd4096;
      5'd13:   val = 28'sd2048;
      5'd14:   val = 28'sd1024;
      5'd15:   val = 28'sd512;
      5'd16:   val = 28'sd256;
      5'd17:   val = 28'sd128;
      5'd18:   val = 28'sd64;
      5'd19:   val = 28'sd32;
      5'd20:   val = 28'sd16;
      5'd21:   val = 28'sd8;
      5'd22:   val = 28'sd4;
      5'd23:   val = 28'sd2;
      5'd24:   val = 28'sd1;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

@@ rtl/vpa_prerot.sv @@
// ============================================================================
// vpa_prerot
// Input stage: scales the vector, detects the origin and turns left-half
// vectors by a quarter turn so that x is not negative.
// ============================================================================
module vpa_prerot (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  vpa_pkg::vpa_in_t    data_i,
  output logic                valid_o,
  output vpa_pkg::vpa_stage_t stage_o
);
  import vpa_pkg::*;

  logic                         valid_q;
  vpa_stage_t                   stage_d, stage_q;
  logic signed [DataWidth-1:0]  x_s, y_s;

  always_comb begin
    x_s = DataWidth'(data_i.x_coord) <<< FracBits;
    y_s = DataWidth'(data_i.y_coord) <<< FracBits;
    stage_d.origin = (data_i.x_coord == '0) && (data_i.y_coord == '0);
    stage_d.x = x_s;
    stage_d.y = y_s;
    stage_d.z = '0;
    if (x_s < 0) begin
      if (y_s >= 0) begin
        stage_d.x = y_s;
        stage_d.y = -x_s;
        stage_d.z = HalfPiQ24;
      end else begin
        stage_d.x = -y_s;
        stage_d.y = x_s;
        stage_d.z = -HalfPiQ24;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

@@ rtl/vpa_cell.sv @@
// ============================================================================
// vpa_cell
// One CORDIC vectoring micro-rotation, registered, handing its vector and
// angle sum to the next cell every cycle.
// ============================================================================
module vpa_cell (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic [vpa_pkg::ShiftWidth-1:0]           shift_i,
  input  logic signed [vpa_pkg::AngleWidth-1:0]    atan_i,
  input  logic                                     valid_i,
  input  vpa_pkg::vpa_stage_t                      stage_i,
  output logic                                     valid_o,
  output vpa_pkg::vpa_stage_t                      stage_o
);
  import vpa_pkg::*;

  logic                        valid_q;
  vpa_stage_t                  stage_d, stage_q;
  logic signed [DataWidth-1:0] xs, ys;

  always_comb begin
    xs = stage_i.x >>> shift_i;
    ys = stage_i.y >>> shift_i;
    stage_d.origin = stage_i.origin;
    if (!stage_i.y[DataWidth-1]) begin
      stage_d.x = stage_i.x + ys;
      stage_d.y = stage_i.y - xs;
      stage_d.z = stage_i.z + atan_i;
    end else begin
      stage_d.x = stage_i.x - ys;
      stage_d.y = stage_i.y + xs;
      stage_d.z = stage_i.z - atan_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

@@ rtl/vpa_round.sv @@
// ============================================================================
// vpa_round
// Output stage: rounds the angle sum to Q2.13, clamps sums above plus pi to
// plus pi, folds minus pi onto plus pi and forces the origin case to zero.
// ============================================================================
module vpa_round (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  vpa_pkg::vpa_stage_t stage_i,
  output logic                valid_o,
  output vpa_pkg::vpa_out_t   result_o
);
  import vpa_pkg::*;

  logic                         valid_q;
  vpa_out_t                     result_d, result_q;
  logic signed [AngleWidth-1:0] sum;
  logic signed [ResWidth-1:0]   res;
  logic signed [ResWidth-1:0]   sat;

  always_comb begin
    sum = stage_i.z + RoundConst;
    res = sum[AngleWidth-1:ExtraBits];
    if (res > PiQ13 || res <= NegPiQ13) begin
      sat = PiQ13;
    end else begin
      sat = res;
    end
    result_d.at_origin = stage_i.origin;
    result_d.angle     = stage_i.origin ? 16'sd0 : sat[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      result_q <= result_d;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

@@ rtl/vector_polar_angle.sv @@
// ============================================================================
// vector_polar_angle
// Polar angle of a signed vector, atan2(y, x), in Q2.13 radians.
// ============================================================================
// A new vector is taken on every clock cycle and busy_o never rises. Each
// result appears on done_o after its start beat has passed through one input
// stage, one registered cell per micro-rotation and one rounding stage. The
// receiver cannot stall, so every result beat must be taken in the cycle it
// is shown.
module vector_polar_angle (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  vpa_pkg::vpa_in_t  in_i,
  output logic              busy_o,
  output logic              done_o,
  output vpa_pkg::vpa_out_t result_o
);
  import vpa_pkg::*;

  localparam int Latency = NumCells + 2;

  logic       valid_s [NumCells+1];
  vpa_stage_t stage_s [NumCells+1];

  assign busy_o = 1'b0;

  vpa_prerot u_prerot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .data_i  (in_i),
    .valid_o (valid_s[0]),
    .stage_o (stage_s[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    vpa_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (ShiftWidth'(i)),
      .atan_i  (atan_q24(ShiftWidth'(i))),
      .valid_i (valid_s[i]),
      .stage_i (stage_s[i]),
      .valid_o (valid_s[i+1]),
      .stage_o (stage_s[i+1])
    );
  end

  vpa_round u_round (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid_s[NumCells]),
    .stage_i  (stage_s[NumCells]),
    .valid_o  (done_o),
    .result_o (result_o)
  );

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##Latency done_o)
    else $error("result beat missing after fixed latency");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.angle > -16'sd25736 && result_o.angle <= 16'sd25736))
    else $error("angle outside (-pi, pi]");

  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.at_origin) |-> (result_o.angle == 16'sd0))
    else $error("origin result with nonzero angle");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(rst_ni, Latency)) |-> $past(start_i, Latency))
    else $error("result beat without a start beat");

endmodule

@@ sim/vector_polar_angle_tb.sv @@
// ============================================================================
// vector_polar_angle_tb
// Self-checking bench for the pipelined polar angle block.
// ============================================================================
// Vectors are sent as command beats with random gaps and checked against a
// bit-true CORDIC predictor. A directed set covers the axes, the corners, the
// origin and angles that round to minus pi. A long random set follows, mixing
// full-range, small, near-axis and near-minus-pi vectors.
`timescale 1ns / 100ps

module vector_polar_angle_tb;
  import vpa_pkg::*;

  typedef struct {
    vpa_in_t payload;
    int      gap;
    bit      drain;
  } vector_beat_t;

  localparam int  CycleLimit = 150000;
  localparam int  TailCycles = 40;
  localparam longint PiQ13Ref   = 25736;
  localparam longint HalfPiRef  = 26353589;
  localparam longint PreScale   = 64'd16777216;
  localparam longint AtanRef [25] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2, 1
  };

  logic     clk_i;
  logic     rst_ni;
  logic     start_i;
  vpa_in_t  in_i;
  logic     busy_o;
  logic     done_o;
  vpa_out_t result_o;

  vector_beat_t vector_queue[$];
  vpa_out_t     angle_queue[$];
  logic         beat_taken;
  int           gap_left;
  int           mismatch_count;
  int           cycle_count;

  vector_polar_angle dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .in_i     (in_i),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .result_o (result_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic vpa_out_t polar_angle(input vpa_in_t v);
    vpa_out_t res;
    longint   x;
    longint   y;
    longint   z;
    longint   t;
    longint   xs;
    longint   ys;
    longint   r;
    int       n;
    res = '0;
    x = longint'(v.x_coord);
    y = longint'(v.y_coord);
    z = 0;
    if (x == 0 && y == 0) begin
      res.at_origin = 1'b1;
      return res;
    end
    x = x * PreScale;
    y = y * PreScale;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t;
        z = HalfPiRef;
      end else begin
        t = x; x = -y; y = t;
        z = -HalfPiRef;
      end
    end
    n = (Iterations > 25) ? 25 : Iterations;
    for (int i = 0; i < n; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + AtanRef[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - AtanRef[i];
      end
    end
    r = (z + 1024) >>> 11;
    if (r > PiQ13Ref) r = PiQ13Ref;
    if (r <= -PiQ13Ref) r = PiQ13Ref;
    res.angle = 16'(r);
    return res;
  endfunction

  function automatic logic signed [15:0] random_coord(input int kind);
    logic signed [15:0] c;
    case (kind)
      0: c = 16'($urandom);
      1: c = 16'(int'($urandom_range(0, 16)) - 8);
      2: c = 16'(int'($urandom_range(0, 32767)) - 32768);
      default: begin
        case ($urandom_range(0, 5))
          0: c = 16'sh7fff;
          1: c = 16'sh8000;
          2: c = 16'sh0000;
          3: c = 16'sh0001;
          4: c = 16'shffff;
          default: c = 16'sh8001;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic int random_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_vector(input logic signed [15:0] x, input logic signed [15:0] y,
                            input int gap, input bit drain);
    vector_beat_t b;
    b.payload.x_coord = x;
    b.payload.y_coord = y;
    b.gap = gap;
    b.drain = drain;
    vector_queue.push_back(b);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !beat_taken) begin
      end else if (gap_left > 0) begin
        start_i <= 1'b0;
        gap_left = gap_left - 1;
      end else if (vector_queue.size() > 0 &&
                   !(vector_queue[0].drain && angle_queue.size() != 0)) begin
        start_i <= 1'b1;
        in_i <= vector_queue[0].payload;
        gap_left = vector_queue[0].gap;
        void'(vector_queue.pop_front());
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    vpa_out_t want;
    beat_taken <= start_i && !busy_o;
    if (rst_ni && start_i && !busy_o) angle_queue.push_back(polar_angle(in_i));
    if (rst_ni && done_o) begin
      if (angle_queue.size() == 0) begin
        $display("%0t: unexpected result beat, actual angle %0d at_origin %0b",
                 $time, result_o.angle, result_o.at_origin);
        mismatch_count++;
      end else begin
        want = angle_queue.pop_front();
        if (result_o.angle !== want.angle || result_o.at_origin !== want.at_origin) begin
          $display("%0t: expected angle %0d at_origin %0b, actual angle %0d at_origin %0b",
                   $time, want.angle, want.at_origin, result_o.angle, result_o.at_origin);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int kind_x;
    int kind_y;
    bit quiet;
    start_i = 1'b0;
    in_i = '0;
    rst_ni = 1'b0;
    beat_taken = 1'b0;
    gap_left = 0;
    mismatch_count = 0;
    cycle_count = 0;

    add_vector(16'sh0000, 16'sh0000, 0, 1'b0);
    add_vector(16'sh7fff, 16'sh0000, 0, 1'b0);
    add_vector(16'sh8000, 16'sh0000, 1, 1'b0);
    add_vector(16'sh0000, 16'sh7fff, 0, 1'b0);
    add_vector(16'sh0000, 16'sh8000, 0, 1'b0);
    add_vector(16'sh7fff, 16'sh7fff, 2, 1'b0);
    add_vector(16'sh8000, 16'sh8000, 0, 1'b0);
    add_vector(16'sh7fff, 16'sh8000, 0, 1'b0);
    add_vector(16'sh8000, 16'sh7fff, 0, 1'b0);
    add_vector(16'sh8000, 16'shffff, 0, 1'b0);
    add_vector(16'sh8000, 16'sh0001, 3, 1'b0);
    add_vector(-16'sd20000, 16'shffff, 0, 1'b0);
    add_vector(16'shffff, 16'shffff, 0, 1'b0);
    add_vector(16'shffff, 16'sh0000, 0, 1'b0);
    add_vector(16'shffff, 16'sh0001, 0, 1'b0);
    add_vector(16'sh0001, 16'sh0000, 0, 1'b0);
    add_vector(16'sh0000, 16'sh0001, 0, 1'b0);
    add_vector(16'sh0000, 16'shffff, 0, 1'b0);
    add_vector(16'sh0001, 16'shffff, 0, 1'b0);
    add_vector(16'sh8001, 16'shffff, 0, 1'b0);
    add_vector(16'sd3, 16'sd4, 0, 1'b0);
    add_vector(-16'sd3, 16'sd4, 0, 1'b0);
    add_vector(16'sh5555, 16'shaaaa, 0, 1'b0);

    quiet = 1'b0;
    for (int i = 0; i < 1150; i++) begin
      if (i % 100 == 0) quiet = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin kind_x = 0; kind_y = 0; end
        4, 5:       begin kind_x = 1; kind_y = 1; end
        6:          begin kind_x = 2; kind_y = 1; end
        7:          begin kind_x = 0; kind_y = 1; end
        8:          begin kind_x = 1; kind_y = 0; end
        default:    begin kind_x = 3; kind_y = 3; end
      endcase
      add_vector(random_coord(kind_x), random_coord(kind_y), random_gap(quiet),
                 (i == 0 || i == 600));
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (vector_queue.size() != 0 || (start_i && !(beat_taken || !busy_o)) ||
           angle_queue.size() != 0);
    repeat (TailCycles) @(posedge clk_i);
    #1;
    if (mismatch_count == 0 && angle_queue.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/vpa_pkg.sv
rtl/vpa_prerot.sv
rtl/vpa_cell.sv
rtl/vpa_round.sv
rtl/vector_polar_angle.sv
sim/vector_polar_angle_tb.sv
